/* src/sha256_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // One entry of the queue between the front end and the compression engine.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [5:0] LengthStart = 6'd56;

    typedef logic [31:0] t_word;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

/* src/sha256_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input items, drops bare idle items and queues the rest for the
// compression engine in a small FIFO.
// ----------------------------------------------------------------------------
module sha256_front
    import sha256_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_message,
    output logic            o_item_valid,
    input  wire logic       i_item_ready,
    output t_item           o_item
);

    t_item                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_count;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_useful;

    // Items with neither a byte nor an end marker carry no work.
    assign w_useful     = i_has_byte | i_end_of_message;
    assign o_ready      = (r_count != QueueDepth[QueuePtrW:0]);
    assign w_push       = i_valid & o_ready & w_useful;
    assign o_item_valid = (r_count != '0);
    assign w_pop        = o_item_valid & i_item_ready;
    assign o_item       = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_data_byte, has_byte: i_has_byte,
                                 end_of_message: i_end_of_message};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + {{QueuePtrW{1'b0}}, w_push}
                               - {{QueuePtrW{1'b0}}, w_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == QueueDepth[QueuePtrW:0] |-> !w_push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> !w_pop)
        else $error("queue underflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[QueuePtrW-1:0] == (r_wr_ptr - r_rd_ptr))
        else $error("pointer gap differs from fill level");
`endif

endmodule
`default_nettype wire

/* src/sha256_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Gathers bytes into the schedule window, pads the final block, runs one
// round per cycle and emits the eight digest words through an output register.
// ----------------------------------------------------------------------------
module sha256_engine
    import sha256_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_item_valid,
    output logic      o_item_ready,
    input  t_item     i_item,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_word     o_digest_word,
    output logic [2:0] o_word_index,
    output logic      o_last_word
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } t_state;

    t_state      r_state;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [63:0] r_count;
    logic [5:0]  r_pos;
    logic [5:0]  r_round;
    logic        r_closing;
    logic        r_length_done;
    logic        r_len_next;
    logic [2:0]  r_idx;
    logic        r_valid;
    t_word       r_word;

    t_word       w_new_w;
    t_word       w_wt;
    t_word       w_t1;
    t_word       w_t2;
    logic [7:0]  w_pad_byte;
    logic [63:0] w_bits;

    assign o_item_ready  = (r_state == S_LOAD);
    assign o_valid       = r_valid;
    assign o_digest_word = r_word;
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);
    assign w_bits        = {r_count[60:0], 3'b000};

    // Message schedule expansion on the rolling sixteen-word window.
    assign w_new_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign w_wt    = (r_round < 6'd16) ? r_w[0] : w_new_w;

    // Round function.
    assign w_t1 = r_v[7] + big_sigma1(r_v[4])
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[r_round] + w_wt;
    assign w_t2 = big_sigma0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Padding byte for the current position of the final block(s). The length
    // goes into the last eight bytes unless the marker itself fell there.
    always_comb begin
        if (!r_len_next && r_pos >= LengthStart && !r_closing) begin
            w_pad_byte = w_bits[8*(7 - r_pos[2:0]) +: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // Sequencer, window, working and chaining registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_count       <= '0;
            r_pos         <= '0;
            r_round       <= '0;
            r_closing     <= 1'b0;
            r_length_done <= 1'b0;
            r_len_next    <= 1'b0;
            r_idx         <= '0;
            r_valid       <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_item_valid) begin
                        logic [5:0] pos;
                        pos = r_pos;
                        if (i_item.has_byte) begin
                            r_w[pos[5:2]] <= {r_w[pos[5:2]][23:0], i_item.data_byte};
                            r_count <= r_count + 64'd1;
                        end
                        if (i_item.has_byte && pos == 6'd63) begin
                            r_pos     <= '0;
                            r_closing <= i_item.end_of_message;
                            r_state   <= S_ROUND;
                            r_round   <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end else if (i_item.has_byte) begin
                            r_pos <= pos + 6'd1;
                            if (i_item.end_of_message) begin
                                r_closing <= 1'b1;
                                r_state   <= S_PAD;
                            end
                        end else begin
                            r_closing <= 1'b1;
                            r_state   <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // r_closing set means the 0x80 marker is still to go.
                    r_w[r_pos[5:2]] <= {r_w[r_pos[5:2]][23:0],
                                        r_closing ? PadByte : w_pad_byte};
                    r_closing <= 1'b0;
                    // A marker in the last eight bytes pushes the length
                    // into one more block.
                    if (r_closing) r_len_next <= (r_pos >= LengthStart);
                    if (r_pos == 6'd63) begin
                        r_length_done <= !(r_closing || r_len_next);
                        r_pos   <= '0;
                        r_round <= '0;
                        r_state <= S_ROUND;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        r_pos <= r_pos + 6'd1;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wt;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_FINAL;
                end
                S_FINAL: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_length_done) begin
                        r_length_done <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else if (r_closing) begin
                        // A full block ended the message: pad a fresh block.
                        r_state <= S_PAD;
                    end else if (r_len_next) begin
                        // The length still has to go into a block of its own.
                        r_len_next <= 1'b0;
                        r_state    <= S_PAD;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    if (!r_valid || i_ready) begin
                        if (r_valid && r_idx == 3'd7) begin
                            r_valid <= 1'b0;
                            r_count <= '0;
                            r_idx   <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
                            r_state <= S_LOAD;
                        end else begin
                            r_word  <= r_h[r_valid ? r_idx + 3'd1 : r_idx];
                            if (r_valid) r_idx <= r_idx + 3'd1;
                            r_valid <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_EMIT)
        else $error("digest shown outside emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_word) && $stable(r_idx))
        else $error("digest word changed while stalled");
    a_round_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_ROUND) |-> r_round == 6'd0)
        else $error("compression started mid-count");
`endif

endmodule
`default_nettype wire

/* src/sha256_message_hasher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-serial SHA-256 with a decoupled input queue and a one-round-per-cycle
// compression engine.
// ----------------------------------------------------------------------------
// One message byte is taken per transfer into a four-entry queue; the engine
// drains one byte per cycle into the block window while it is loading, and
// every 64th byte starts a compression of the block followed by a fold of the
// working words into the chaining words. An end-of-message transfer pads the
// rest of the block one byte per cycle, compresses one or two more blocks and
// then shows the eight digest words, one per transfer, most significant first.
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    sha256_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_has_byte      (i_has_byte),
        .i_end_of_message(i_end_of_message),
        .o_item_valid    (w_item_valid),
        .i_item_ready    (w_item_ready),
        .o_item          (w_item)
    );

    sha256_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

endmodule
`default_nettype wire

/* test/sha256_digest_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the hasher. It predicts the digest words of each
// message from the accepted bytes and compares every output transfer.
// ----------------------------------------------------------------------------
module sha256_digest_checker
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_word_index,
    input  wire logic        i_last_word,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_entry;

    t_digest_entry digest_queue[$];
    logic [31:0]   hash_state [8];
    logic [7:0]    msg_block [64];
    logic [63:0]   msg_length;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the current block into the hash state.
    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    // Absorbs one input transfer and queues the digest words on an end item.
    task automatic absorb_item(input logic [7:0] b, input logic hb, input logic eom);
        int          idx;
        logic [63:0] bits;
        if (hb) begin
            idx = int'(msg_length[5:0]);
            msg_block[idx] = b;
            msg_length++;
            if (idx == 63) compress_msg_block();
        end
        if (eom) begin
            bits = msg_length << 3;
            idx = int'(msg_length[5:0]);
            msg_block[idx] = PadByte;
            idx++;
            if (idx > 56) begin
                while (idx < 64) msg_block[idx++] = 8'h00;
                compress_msg_block();
                idx = 0;
            end
            while (idx < 56) msg_block[idx++] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++)
                digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
            hash_state = InitH;
            msg_length = '0;
        end
    endtask

    initial begin
        o_fail_count = 0;
        hash_state = InitH;
        msg_length = '0;
    end

    assign o_pending = digest_queue.size();

    // Both channels are observed at the rising edge.
    always @(posedge i_clk) begin
        t_digest_entry exp_entry;
        if (i_rst_n) begin
            if (i_valid && i_ready)
                absorb_item(i_data_byte, i_has_byte, i_end_of_message);
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest transfer: word %h", i_digest_word);
                    o_fail_count++;
                end else begin
                    exp_entry = digest_queue.pop_front();
                    if (i_digest_word !== exp_entry.word) begin
                        $error("digest_word: expected %h, got %h",
                               exp_entry.word, i_digest_word);
                        o_fail_count++;
                    end
                    if (i_word_index !== exp_entry.index) begin
                        $error("word_index: expected %0d, got %0d",
                               exp_entry.index, i_word_index);
                        o_fail_count++;
                    end
                    if (i_last_word !== exp_entry.last) begin
                        $error("last_word: expected %0d, got %0d",
                               exp_entry.last, i_last_word);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* test/sha256_message_hasher_core_test.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds directed and random messages byte by byte with random gaps and output
// stalls, including one long stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core_test;

    localparam int CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        stimulus_done;
    logic        long_hold;

    sha256_message_hasher_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(data_byte), .i_has_byte(has_byte),
        .i_end_of_message(end_of_message),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_digest_word(digest_word), .o_word_index(word_index),
        .o_last_word(last_word)
    );

    sha256_digest_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready(in_ready),
        .i_data_byte(data_byte), .i_has_byte(has_byte),
        .i_end_of_message(end_of_message),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_digest_word(digest_word), .i_word_index(word_index),
        .i_last_word(last_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offers one item and holds it until the transfer.
    task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        has_byte       <= hb;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input logic bare_end);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, !bare_end && i == len - 1);
        if (bare_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: random stalls, plus one long hold-off early in the random part.
    initial begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        while (1) begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                long_hold = 1'b0;
            end
            stall = (cycle_count % 3000 < 1000) ? 0 : gap_length();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("sha256_message_hasher_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        int len;
        int sent;
        int wait_cycles;
        cycle_count    = 0;
        long_hold      = 1'b0;
        stimulus_done  = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        has_byte       = 1'b0;
        end_of_message = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty message, idle items, byte extremes, padding edges.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        send_message(64, 1'b1);

        // Random messages, short ones mostly; the long stall fills the input queue.
        sent = 0;
        long_hold = 1'b1;
        while (sent < 180) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(100, 140);
                1, 2:    len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 12);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1,
                          (i == len - 1) && $urandom_range(0, 1));
            end
            if (len == 0 || !end_of_message) send_item(8'($urandom), 1'b0, 1'b1);
            sent += len + 1;
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;

        wait_cycles = 0;
        while (pending > 0 && wait_cycles < 20000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (300) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sha256_message_hasher_core_test: PASS");
        end else begin
            $display("sha256_message_hasher_core_test: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/sha256_pkg.sv
src/sha256_front.sv
src/sha256_engine.sv
src/sha256_message_hasher_core.sv
test/sha256_digest_checker.sv
test/sha256_message_hasher_core_test.sv
